/* hw/rtl/occ_pkg.sv */
// Package of the orbit camera controller: beat payload types, register indexes,
// Q30 angle constants and the CORDIC arctangent table.
// Depends on nothing; the top and the testbench import it.
`default_nettype none

package occ_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned DELTA_W = 20;

  // Angle registers (Q30 radians) and CORDIC vector registers.
  localparam int unsigned AW = 35;
  localparam int unsigned CW = 36;

  localparam int unsigned MUL_W          = 35;
  localparam int unsigned SQRT_STEPS     = 32;
  localparam int unsigned DIV_STEPS      = 60;
  localparam int unsigned CORDIC_STEPS   = 30;

  localparam logic [1:0] ACT_SET_VIEW = 2'd0;
  localparam logic [1:0] ACT_ORBIT    = 2'd1;
  localparam logic [1:0] ACT_DOLLY    = 2'd2;
  localparam logic [1:0] ACT_RESTRICT = 2'd3;

  localparam logic CFG_MIN_DIST = 1'b0;
  localparam logic CFG_MAX_DIST = 1'b1;

  localparam logic [CFG_W-1:0] MIN_DIST_RESET = 31'd65536;
  localparam logic [CFG_W-1:0] MAX_DIST_RESET = 31'd655360;

  localparam logic signed [AW-1:0] Q30_PI       = 35'sd3373259426;
  localparam logic signed [AW-1:0] Q30_TWO_PI   = 35'sd6746518852;
  localparam logic signed [AW-1:0] Q30_HALF_PI  = 35'sd1686629713;
  localparam logic signed [AW-1:0] Q30_ONE_DEG  = 35'sd18740330;
  localparam logic signed [AW-1:0] Q30_PI_M_DEG = 35'sd3354519096;
  localparam logic signed [CW-1:0] Q30_GAIN     = 36'sd652032874;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [COORD_W-1:0]  new_eye_x;
    logic signed [COORD_W-1:0]  new_eye_y;
    logic signed [COORD_W-1:0]  new_eye_z;
    logic signed [COORD_W-1:0]  new_target_x;
    logic signed [COORD_W-1:0]  new_target_y;
    logic signed [COORD_W-1:0]  new_target_z;
    logic signed [DELTA_W-1:0]  azimuth_delta;
    logic signed [DELTA_W-1:0]  elevation_delta;
    logic signed [COORD_W-1:0]  move_distance;
  } occ_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } occ_out_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    case (idx)
      5'd0:  return 30'h3243F6A8;
      5'd1:  return 30'h1DAC6705;
      5'd2:  return 30'h0FADBAFC;
      5'd3:  return 30'h07F56EA6;
      5'd4:  return 30'h03FEAB76;
      5'd5:  return 30'h01FFD55B;
      5'd6:  return 30'h00FFFAAA;
      5'd7:  return 30'h007FFF55;
      5'd8:  return 30'h003FFFEA;
      5'd9:  return 30'h001FFFFD;
      5'd10: return 30'h000FFFFF;
      5'd11: return 30'h0007FFFF;
      5'd12: return 30'h0003FFFF;
      5'd13: return 30'h0001FFFF;
      5'd14: return 30'h0000FFFF;
      5'd15: return 30'h00007FFF;
      5'd16: return 30'h00003FFF;
      5'd17: return 30'h00001FFF;
      5'd18: return 30'h00000FFF;
      5'd19: return 30'h000007FF;
      5'd20: return 30'h000003FF;
      5'd21: return 30'h000001FF;
      5'd22: return 30'h000000FF;
      5'd23: return 30'h0000007F;
      5'd24: return 30'h0000003F;
      5'd25: return 30'h0000001F;
      5'd26: return 30'h0000000F;
      5'd27: return 30'h00000008;
      5'd28: return 30'h00000004;
      5'd29: return 30'h00000002;
      default: return 30'h0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/occ_stream_if.sv */
// Valid/ready stream channel used for the request and result beats.
// The payload type is a parameter; the types come from occ_pkg.
`default_nettype none

interface occ_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/orbit_camera_controller_top.sv */
// Orbit camera controller: sequencer with a bit-serial multiplier, divider,
// square root and an iterative CORDIC. Depends on occ_pkg and occ_stream_if.
//
// One request beat is taken at a time; a new one is accepted as soon as the
// previous result sits in the output register. A distance restriction runs up
// to two dolly moves after a length. The arithmetic uses the shift-add multiplier,
// the restoring divider (run once an axis), the square root and the CORDIC.
`default_nettype none

module orbit_camera_controller_top import occ_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  occ_stream_if.sink            in_if,
  occ_stream_if.source          out_if
);

  typedef enum logic [5:0] {
    S_IDLE, S_FIN,
    S_L_INIT, S_L_SQ, S_MUL, S_L_ACC, S_L_SQRT, S_L_DONE,
    S_C_PRE, S_C_RED1, S_C_RED2, S_C_RUN,
    S_O_H, S_O_H_ADD, S_O_WRAP, S_O_R, S_O_V, S_O_V_ADD, S_O_CLAMP,
    S_O_SCV, S_O_SCV_DONE, S_O_SCH_DONE, S_O_U, S_O_U_DONE, S_O_EYE_MUL,
    S_O_EYE_WR,
    S_D_START, S_D_CLAMP, S_D_DIV, S_D_DIV_RUN, S_D_MUL, S_D_WR, S_D_END,
    S_R_CHECK, S_R_SECOND
  } state_e;

  state_e state_q, lret_q, mret_q, cret_q, dret_q;

  logic [CFG_W-1:0] min_q, max_q;

  logic signed [COORD_W-1:0] eye_q [3];
  logic signed [COORD_W-1:0] tgt_q [3];

  logic [1:0] ax_q;
  logic [5:0] cnt_q;
  logic       hmode_q;
  logic       lt_q;

  logic [MUL_W-1:0]   mul_a_q;
  logic [2*MUL_W-1:0] mul_p_q;
  logic               mul_neg_q;

  logic [63:0] sum_q, rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;

  logic [59:0] num_q;
  logic [32:0] drem_q;
  logic        dneg_q;

  logic [32:0] len_q, rl_q, lold_q;

  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [AW-1:0] cz_q;
  logic                 cvec_q, cneg_q;

  logic signed [AW-1:0]      h_q, v_q, req_q;
  logic signed [DELTA_W-1:0] daz_q, del_q;
  logic signed [COORD_W-1:0] cv_q, sv_q, ch_q, sh_q, u_q;

  occ_out_t out_q;
  logic     out_valid_q;

  function automatic logic [MUL_W-1:0] mag35(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] n;
    n = -v;
    return v[CW-1] ? n[MUL_W-1:0] : v[MUL_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -44'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // View vector and its magnitudes per axis.
  logic signed [32:0] d33 [3];
  logic [31:0]        dabs [3];
  logic signed [32:0] dneg_v [3];
  logic               s_sel;
  logic [30:0]        sq_op;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d33[k]    = 33'(tgt_q[k]) - 33'(eye_q[k]);
      dneg_v[k] = -d33[k];
      dabs[k]   = d33[k][32] ? dneg_v[k][31:0] : d33[k][31:0];
    end
    s_sel = hmode_q ? (dabs[0][31] | dabs[1][31])
                    : (dabs[0][31] | dabs[1][31] | dabs[2][31]);
    sq_op = s_sel ? dabs[ax_q][31:1] : dabs[ax_q][30:0];
  end

  logic [MUL_W:0]        mul_sum;
  logic [2*MUL_W-1:0]    mul_next;
  logic signed [2*MUL_W:0] mres;

  always_comb begin
    mul_sum  = {1'b0, mul_p_q[2*MUL_W-1:MUL_W]} + {1'b0, mul_a_q};
    mul_next = mul_p_q[0] ? {mul_sum, mul_p_q[MUL_W-1:1]}
                          : {1'b0, mul_p_q[2*MUL_W-1:1]};
    mres     = mul_neg_q ? -$signed({1'b0, mul_p_q}) : $signed({1'b0, mul_p_q});
  end

  logic [35:0] srem2, strial, sdiff;
  logic        sge;
  logic [33:0] drem2, ddiff;
  logic        dge;

  always_comb begin
    srem2  = {rem_q, rad_q[63:62]};
    strial = {2'b00, root_q, 2'b01};
    sge    = srem2 >= strial;
    sdiff  = srem2 - strial;
    drem2  = {drem_q, num_q[59]};
    dge    = drem2 >= {1'b0, len_q};
    ddiff  = drem2 - {1'b0, len_q};
  end

  logic signed [CW-1:0] cxs, cys;
  logic signed [AW-1:0] ctab;
  logic                 cup;

  always_comb begin
    cxs  = cx_q >>> cnt_q[4:0];
    cys  = cy_q >>> cnt_q[4:0];
    ctab = $signed({5'b0, atan_entry(cnt_q[4:0])});
    cup  = cvec_q ? cy_q[CW-1] : !cz_q[AW-1];
  end

  logic signed [AW-1:0] lo_v, hi_v;
  logic [32:0]          lres;
  logic signed [43:0]   eye_sum, eye_diff;
  logic signed [CW-1:0] cos_v, sin_v;

  always_comb begin
    lo_v     = $signed({2'b0, len_q}) - $signed({4'b0, max_q});
    hi_v     = $signed({2'b0, len_q}) - $signed({4'b0, min_q});
    lres     = s_sel ? {root_q, 1'b0} : {1'b0, root_q};
    eye_sum  = 44'(eye_q[ax_q]) + 44'($signed(mres[2*MUL_W:28]));
    eye_diff = 44'(tgt_q[ax_q]) - 44'($signed(mres[2*MUL_W:30]));
    cos_v    = cneg_q ? -cx_q : cx_q;
    sin_v    = cneg_q ? -cy_q : cy_q;
  end

  assign in_if.ready    = (state_q == S_IDLE);
  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_DIST_RESET;
      max_q <= MAX_DIST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_DIST: min_q <= cfg_data_i;
        CFG_MAX_DIST: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lret_q      <= S_IDLE;
      mret_q      <= S_IDLE;
      cret_q      <= S_IDLE;
      dret_q      <= S_IDLE;
      for (int k = 0; k < 3; k++) begin
        eye_q[k] <= '0;
        tgt_q[k] <= '0;
      end
      ax_q        <= '0;
      cnt_q       <= '0;
      hmode_q     <= 1'b0;
      lt_q        <= 1'b0;
      mul_a_q     <= '0;
      mul_p_q     <= '0;
      mul_neg_q   <= 1'b0;
      sum_q       <= '0;
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      num_q       <= '0;
      drem_q      <= '0;
      dneg_q      <= 1'b0;
      len_q       <= '0;
      rl_q        <= '0;
      lold_q      <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      cvec_q      <= 1'b0;
      cneg_q      <= 1'b0;
      h_q         <= '0;
      v_q         <= '0;
      req_q       <= '0;
      daz_q       <= '0;
      del_q       <= '0;
      cv_q        <= '0;
      sv_q        <= '0;
      ch_q        <= '0;
      sh_q        <= '0;
      u_q         <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_if.ready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            daz_q <= in_if.payload.azimuth_delta;
            del_q <= in_if.payload.elevation_delta;
            req_q <= AW'(in_if.payload.move_distance);
            case (in_if.payload.action)
              ACT_SET_VIEW: begin
                eye_q[0] <= in_if.payload.new_eye_x;
                eye_q[1] <= in_if.payload.new_eye_y;
                eye_q[2] <= in_if.payload.new_eye_z;
                tgt_q[0] <= in_if.payload.new_target_x;
                tgt_q[1] <= in_if.payload.new_target_y;
                tgt_q[2] <= in_if.payload.new_target_z;
                state_q  <= S_FIN;
              end
              ACT_ORBIT: begin
                hmode_q <= 1'b0;
                lret_q  <= S_O_H;
                state_q <= S_L_INIT;
              end
              ACT_DOLLY: begin
                dret_q  <= S_FIN;
                state_q <= S_D_START;
              end
              ACT_RESTRICT: begin
                hmode_q <= 1'b0;
                lret_q  <= S_R_CHECK;
                state_q <= S_L_INIT;
              end
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_if.ready) begin
            out_q.eye_x    <= eye_q[0];
            out_q.eye_y    <= eye_q[1];
            out_q.eye_z    <= eye_q[2];
            out_q.target_x <= tgt_q[0];
            out_q.target_y <= tgt_q[1];
            out_q.target_z <= tgt_q[2];
            out_valid_q    <= 1'b1;
            state_q        <= S_IDLE;
          end
        end

        S_L_INIT: begin
          ax_q    <= '0;
          sum_q   <= '0;
          state_q <= S_L_SQ;
        end
        S_L_SQ: begin
          mul_a_q   <= {4'b0, sq_op};
          mul_p_q   <= {35'b0, 4'b0, sq_op};
          mul_neg_q <= 1'b0;
          cnt_q     <= '0;
          mret_q    <= S_L_ACC;
          state_q   <= S_MUL;
        end
        S_MUL: begin
          mul_p_q <= mul_next;
          cnt_q   <= cnt_q + 6'd1;
          if (cnt_q == 6'(MUL_W - 1)) begin
            state_q <= mret_q;
          end
        end
        S_L_ACC: begin
          if (ax_q == 2'd2 || (hmode_q && ax_q == 2'd1)) begin
            rad_q   <= sum_q + mul_p_q[63:0];
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_L_SQRT;
          end else begin
            sum_q   <= sum_q + mul_p_q[63:0];
            ax_q    <= ax_q + 2'd1;
            state_q <= S_L_SQ;
          end
        end
        S_L_SQRT: begin
          rem_q  <= sge ? sdiff[33:0] : srem2[33:0];
          root_q <= {root_q[30:0], sge};
          rad_q  <= {rad_q[61:0], 2'b00};
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == 6'(SQRT_STEPS - 1)) begin
            state_q <= S_L_DONE;
          end
        end
        S_L_DONE: begin
          if (hmode_q) begin
            rl_q <= lres;
          end else begin
            len_q <= lres;
          end
          state_q <= lret_q;
        end

        S_C_PRE: begin
          cnt_q <= '0;
          if (cx_q == '0 && cy_q == '0) begin
            cz_q    <= '0;
            state_q <= cret_q;
          end else begin
            if (cx_q[CW-1]) begin
              cz_q <= cy_q[CW-1] ? -Q30_PI : Q30_PI;
              cx_q <= -cx_q;
              cy_q <= -cy_q;
            end else begin
              cz_q <= '0;
            end
            state_q <= S_C_RUN;
          end
        end
        S_C_RED1: begin
          if (cz_q > Q30_PI) begin
            cz_q <= cz_q - Q30_TWO_PI;
          end else if (cz_q < -Q30_PI) begin
            cz_q <= cz_q + Q30_TWO_PI;
          end
          state_q <= S_C_RED2;
        end
        S_C_RED2: begin
          if (cz_q > Q30_HALF_PI) begin
            cz_q   <= cz_q - Q30_PI;
            cneg_q <= 1'b1;
          end else if (cz_q < -Q30_HALF_PI) begin
            cz_q   <= cz_q + Q30_PI;
            cneg_q <= 1'b1;
          end else begin
            cneg_q <= 1'b0;
          end
          cx_q    <= Q30_GAIN;
          cy_q    <= '0;
          cnt_q   <= '0;
          state_q <= S_C_RUN;
        end
        S_C_RUN: begin
          if (cup) begin
            cx_q <= cx_q - cys;
            cy_q <= cy_q + cxs;
            cz_q <= cz_q - ctab;
          end else begin
            cx_q <= cx_q + cys;
            cy_q <= cy_q - cxs;
            cz_q <= cz_q + ctab;
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
            state_q <= cret_q;
          end
        end

        S_O_H: begin
          cx_q    <= CW'(d33[0]);
          cy_q    <= CW'(d33[1]);
          cvec_q  <= 1'b1;
          cret_q  <= S_O_H_ADD;
          state_q <= S_C_PRE;
        end
        S_O_H_ADD: begin
          h_q     <= cz_q + AW'($signed({daz_q, 14'b0}));
          state_q <= S_O_WRAP;
        end
        S_O_WRAP: begin
          if (h_q[AW-1]) begin
            h_q <= h_q + Q30_TWO_PI;
          end else if (h_q > Q30_TWO_PI) begin
            h_q <= h_q - Q30_TWO_PI;
          end else begin
            state_q <= S_O_R;
          end
        end
        S_O_R: begin
          hmode_q <= 1'b1;
          lret_q  <= S_O_V;
          state_q <= S_L_INIT;
        end
        S_O_V: begin
          cx_q    <= CW'(d33[2]);
          cy_q    <= $signed({3'b0, rl_q});
          cvec_q  <= 1'b1;
          cret_q  <= S_O_V_ADD;
          state_q <= S_C_PRE;
        end
        S_O_V_ADD: begin
          v_q     <= cz_q + AW'($signed({del_q, 14'b0}));
          state_q <= S_O_CLAMP;
        end
        S_O_CLAMP: begin
          if (v_q < Q30_ONE_DEG) begin
            v_q <= Q30_ONE_DEG;
          end else if (v_q > Q30_PI_M_DEG) begin
            v_q <= Q30_PI_M_DEG;
          end
          state_q <= S_O_SCV;
        end
        S_O_SCV: begin
          cz_q    <= v_q;
          cvec_q  <= 1'b0;
          cret_q  <= S_O_SCV_DONE;
          state_q <= S_C_RED1;
        end
        S_O_SCV_DONE: begin
          cv_q    <= cos_v[31:0];
          sv_q    <= sin_v[31:0];
          cz_q    <= h_q;
          cret_q  <= S_O_SCH_DONE;
          state_q <= S_C_RED1;
        end
        S_O_SCH_DONE: begin
          ch_q    <= cos_v[31:0];
          sh_q    <= sin_v[31:0];
          ax_q    <= '0;
          state_q <= S_O_U;
        end
        S_O_U: begin
          if (ax_q == 2'd2) begin
            u_q     <= cv_q;
            state_q <= S_O_EYE_MUL;
          end else begin
            mul_a_q   <= mag35(CW'(sv_q));
            mul_p_q   <= {35'b0, mag35(CW'((ax_q == 2'd0) ? ch_q : sh_q))};
            mul_neg_q <= sv_q[31] ^ ((ax_q == 2'd0) ? ch_q[31] : sh_q[31]);
            cnt_q     <= '0;
            mret_q    <= S_O_U_DONE;
            state_q   <= S_MUL;
          end
        end
        S_O_U_DONE: begin
          u_q     <= mres[61:30];
          state_q <= S_O_EYE_MUL;
        end
        S_O_EYE_MUL: begin
          mul_a_q   <= mag35(CW'(u_q));
          mul_p_q   <= {35'b0, 2'b0, len_q};
          mul_neg_q <= u_q[31];
          cnt_q     <= '0;
          mret_q    <= S_O_EYE_WR;
          state_q   <= S_MUL;
        end
        S_O_EYE_WR: begin
          eye_q[ax_q] <= sat32(eye_diff);
          if (ax_q == 2'd2) begin
            state_q <= S_FIN;
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= S_O_U;
          end
        end

        S_D_START: begin
          hmode_q <= 1'b0;
          lret_q  <= S_D_CLAMP;
          state_q <= S_L_INIT;
        end
        S_D_CLAMP: begin
          if (req_q < lo_v) begin
            req_q <= lo_v;
          end else if (req_q > hi_v) begin
            req_q <= hi_v;
          end
          ax_q <= '0;
          if (len_q == '0) begin
            state_q <= S_D_END;
          end else begin
            state_q <= S_D_DIV;
          end
        end
        S_D_DIV: begin
          num_q   <= {dabs[ax_q], 28'b0};
          drem_q  <= '0;
          dneg_q  <= d33[ax_q][32];
          cnt_q   <= '0;
          state_q <= S_D_DIV_RUN;
        end
        S_D_DIV_RUN: begin
          drem_q <= dge ? ddiff[32:0] : drem2[32:0];
          num_q  <= {num_q[58:0], dge};
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == 6'(DIV_STEPS - 1)) begin
            state_q <= S_D_MUL;
          end
        end
        S_D_MUL: begin
          mul_a_q   <= {5'b0, num_q[29:0]};
          mul_p_q   <= {35'b0, mag35(CW'(req_q))};
          mul_neg_q <= dneg_q ^ req_q[AW-1];
          cnt_q     <= '0;
          mret_q    <= S_D_WR;
          state_q   <= S_MUL;
        end
        S_D_WR: begin
          eye_q[ax_q] <= sat32(eye_sum);
          if (ax_q == 2'd2) begin
            state_q <= S_D_END;
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= S_D_DIV;
          end
        end
        S_D_END: begin
          state_q <= dret_q;
        end

        S_R_CHECK: begin
          lold_q <= len_q;
          lt_q   <= len_q < {2'b0, min_q};
          if (len_q > {2'b0, max_q}) begin
            req_q   <= lo_v;
            dret_q  <= S_R_SECOND;
            state_q <= S_D_START;
          end else begin
            state_q <= S_R_SECOND;
          end
        end
        S_R_SECOND: begin
          if (lt_q) begin
            req_q   <= $signed({2'b0, lold_q}) - $signed({4'b0, min_q});
            dret_q  <= S_FIN;
            state_q <= S_D_START;
          end else begin
            state_q <= S_FIN;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> (state_q != S_IDLE))
    else $error("request beat accepted but sequencer stayed idle");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result beat raised outside the finish step");

  a_azimuth_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_O_R) |-> (!h_q[AW-1] && h_q <= Q30_TWO_PI))
    else $error("azimuth left the wrap loop out of range");

  a_elevation_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_O_SCV) |-> (v_q >= Q30_ONE_DEG && v_q <= Q30_PI_M_DEG))
    else $error("elevation outside its clamp range");

endmodule

`default_nettype wire

/* test/orbit_camera_controller_top_tb.sv */
// Self-checking testbench of orbit_camera_controller_top: a directed table, then random
// set view, orbit, dolly and restriction beats under several distance limits.
// Depends on occ_pkg, occ_stream_if and the RTL of the block.
`default_nettype none

module orbit_camera_controller_top_tb;
  import occ_pkg::*;

  localparam int RANDOM_ITEMS = 1425;
  localparam int LONG_HOLD = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  occ_stream_if #(.payload_t(occ_in_t)) in_if ();
  occ_stream_if #(.payload_t(occ_out_t)) out_if ();

  orbit_camera_controller_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
  end

  typedef struct {
    occ_in_t  item;
    bit       typed;
    occ_out_t want;
  } row_t;

  longint eye_pos[3];
  longint tgt_pos[3];
  longint min_dist;
  longint max_dist;
  occ_out_t pending_views[$];
  int errors = 0;
  bit hold_pending = 1'b0;

  longint arc_step[30] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
  };

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint span(longint a, longint b, longint c);
    longint unsigned ua, ub, uc, m;
    int s;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    uc = (c < 0) ? -c : c;
    m = (ua > ub) ? ua : ub;
    if (uc > m) m = uc;
    s = 0;
    while ((m >> s) >= (64'd1 << 31)) s++;
    ua = ua >> s;
    ub = ub >> s;
    uc = uc >> s;
    return longint'(root64(ua * ua + ub * ub + uc * uc) << s);
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(Q30_PI) : -longint'(Q30_PI);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 30; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arc_step[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arc_step[i];
      end
      x = nx;
    end
    return z;
  endfunction

  task automatic rotate(input longint a, output longint c, output longint s);
    longint x, y, nx;
    bit neg;
    x = Q30_GAIN;
    y = 0;
    neg = 1'b0;
    if (a > Q30_PI) a = a - Q30_TWO_PI;
    if (a < -longint'(Q30_PI)) a = a + Q30_TWO_PI;
    if (a > Q30_HALF_PI) begin
      a = a - Q30_PI;
      neg = 1'b1;
    end else if (a < -longint'(Q30_HALF_PI)) begin
      a = a + Q30_PI;
      neg = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a = a - arc_step[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a = a + arc_step[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic dolly_step(input longint req);
    longint d[3];
    longint len, lo, hi, u;
    for (int i = 0; i < 3; i++) d[i] = tgt_pos[i] - eye_pos[i];
    len = span(d[0], d[1], d[2]);
    lo = len - max_dist;
    hi = len - min_dist;
    if (req < lo) req = lo;
    else if (req > hi) req = hi;
    if (len != 0) begin
      for (int i = 0; i < 3; i++) begin
        u = (d[i] * 64'sd268435456) / len;
        eye_pos[i] = clip32(eye_pos[i] + ((u * req) >>> 28));
      end
    end
  endtask

  task automatic orbit_step(input longint daz, input longint del);
    longint d[3];
    longint u[3];
    longint len, h, v, ch, sh, cv, sv;
    for (int i = 0; i < 3; i++) d[i] = tgt_pos[i] - eye_pos[i];
    len = span(d[0], d[1], d[2]);
    h = angle_of(d[1], d[0]) + daz * 16384;
    while (h < 0) h = h + Q30_TWO_PI;
    while (h > Q30_TWO_PI) h = h - Q30_TWO_PI;
    v = angle_of(span(d[0], d[1], 0), d[2]) + del * 16384;
    if (v < Q30_ONE_DEG) v = Q30_ONE_DEG;
    if (v > Q30_PI_M_DEG) v = Q30_PI_M_DEG;
    rotate(v, cv, sv);
    rotate(h, ch, sh);
    u[0] = (sv * ch) >>> 30;
    u[1] = (sv * sh) >>> 30;
    u[2] = cv;
    for (int i = 0; i < 3; i++) eye_pos[i] = clip32(tgt_pos[i] - ((u[i] * len) >>> 30));
  endtask

  task automatic camera_next(input occ_in_t it, output occ_out_t view);
    longint len;
    case (it.action)
      ACT_SET_VIEW: begin
        eye_pos[0] = longint'($signed(it.new_eye_x));
        eye_pos[1] = longint'($signed(it.new_eye_y));
        eye_pos[2] = longint'($signed(it.new_eye_z));
        tgt_pos[0] = longint'($signed(it.new_target_x));
        tgt_pos[1] = longint'($signed(it.new_target_y));
        tgt_pos[2] = longint'($signed(it.new_target_z));
      end
      ACT_ORBIT: begin
        orbit_step(longint'($signed(it.azimuth_delta)), longint'($signed(it.elevation_delta)));
      end
      ACT_DOLLY: begin
        dolly_step(longint'($signed(it.move_distance)));
      end
      default: begin
        len = span(tgt_pos[0] - eye_pos[0], tgt_pos[1] - eye_pos[1], tgt_pos[2] - eye_pos[2]);
        if (len > max_dist) dolly_step(len - max_dist);
        if (len < min_dist) dolly_step(len - min_dist);
      end
    endcase
    view.eye_x = eye_pos[0][31:0];
    view.eye_y = eye_pos[1][31:0];
    view.eye_z = eye_pos[2][31:0];
    view.target_x = tgt_pos[0][31:0];
    view.target_y = tgt_pos[1][31:0];
    view.target_z = tgt_pos[2][31:0];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
  endtask

  function automatic occ_in_t beat(logic [1:0] act, logic [31:0] ex, logic [31:0] ey,
                                   logic [31:0] ez, logic [31:0] tx, logic [31:0] ty,
                                   logic [31:0] tz, logic [19:0] az, logic [19:0] el,
                                   logic [31:0] mv);
    occ_in_t it;
    it.action = act;
    it.new_eye_x = ex;
    it.new_eye_y = ey;
    it.new_eye_z = ez;
    it.new_target_x = tx;
    it.new_target_y = ty;
    it.new_target_z = tz;
    it.azimuth_delta = az;
    it.elevation_delta = el;
    it.move_distance = mv;
    return it;
  endfunction

  function automatic row_t plain(occ_in_t it);
    row_t r;
    r.item = it;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t known(occ_in_t it, occ_out_t want);
    row_t r;
    r.item = it;
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom();
    if (r < 80) return 32'($signed($urandom_range(0, 2 * 1310720)) - 1310720);
    return 32'($signed($urandom_range(0, 2 * 67108864)) - 67108864);
  endfunction

  function automatic logic [31:0] rand_move();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom();
    return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
  endfunction

  function automatic occ_in_t rand_beat();
    int unsigned r;
    logic [1:0] act;
    r = $urandom_range(0, 99);
    if (r < 15) act = ACT_SET_VIEW;
    else if (r < 50) act = ACT_ORBIT;
    else if (r < 80) act = ACT_DOLLY;
    else act = ACT_RESTRICT;
    return beat(act, rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), 20'($urandom()), 20'($urandom()), rand_move());
  endfunction

  task automatic send(input occ_in_t it, input bit typed, input occ_out_t want);
    int unsigned r, gap;
    occ_out_t view;
    r = $urandom_range(0, 99);
    if (r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 95) gap = $urandom_range(4, 15);
    else gap = $urandom_range(30, 100);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    camera_next(it, view);
    pending_views.push_back(typed ? want : view);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    in_if.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MIN_DIST) min_dist = value;
    else max_dist = value;
  endtask

  always @(posedge clk_i) begin
    occ_out_t want;
    occ_out_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (pending_views.size() == 0) begin
        errors++;
        $display("%0t: result beat with no expectation waiting", $realtime);
      end else begin
        want = pending_views.pop_front();
        if (got.eye_x !== want.eye_x) report_mismatch("eye_x", got.eye_x, want.eye_x);
        if (got.eye_y !== want.eye_y) report_mismatch("eye_y", got.eye_y, want.eye_y);
        if (got.eye_z !== want.eye_z) report_mismatch("eye_z", got.eye_z, want.eye_z);
        if (got.target_x !== want.target_x)
          report_mismatch("target_x", got.target_x, want.target_x);
        if (got.target_y !== want.target_y)
          report_mismatch("target_y", got.target_y, want.target_y);
        if (got.target_z !== want.target_z)
          report_mismatch("target_z", got.target_z, want.target_z);
      end
    end
  end

  initial begin
    int unsigned r;
    @(posedge rst_ni);
    forever begin
      if (hold_pending) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_pending = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_if.ready <= 1'b1;
          @(posedge clk_i);
        end else if (r < 65) begin
          out_if.ready <= 1'b1;
          repeat ($urandom_range(20, 200)) @(posedge clk_i);
        end else if (r < 95) begin
          out_if.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          out_if.ready <= 1'b0;
          repeat ($urandom_range(20, 300)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #(300_000_000);
    $display("orbit_camera_controller_top_tb NOT OK");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [CFG_W-1:0] lo_lim, hi_lim;
    occ_out_t zero_view;
    logic [31:0] mn, mx, one;
    mn = 32'h80000000;
    mx = 32'h7FFFFFFF;
    one = 32'h00010000;
    zero_view = '0;
    min_dist = MIN_DIST_RESET;
    max_dist = MAX_DIST_RESET;
    for (int i = 0; i < 3; i++) begin
      eye_pos[i] = 0;
      tgt_pos[i] = 0;
    end

    // Directed rows: reset state, extremes, zero view vector, clamps and saturation.
    rows.push_back(known(beat(ACT_RESTRICT, 0, 0, 0, 0, 0, 0, 0, 0, 0), zero_view));
    rows.push_back(known(beat(ACT_SET_VIEW, 0, 0, 0, 10 * one, 0, 0, 0, 0, 0),
                         '{0, 0, 0, 10 * one, 0, 0}));
    rows.push_back(plain(beat(ACT_ORBIT, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(plain(beat(ACT_DOLLY, 0, 0, 0, 0, 0, 0, 0, 0, mx)));
    rows.push_back(plain(beat(ACT_DOLLY, 0, 0, 0, 0, 0, 0, 0, 0, mn)));
    rows.push_back(plain(beat(ACT_ORBIT, 0, 0, 0, 0, 0, 0, 20'h7FFFF, 20'h80000, 0)));
    rows.push_back(plain(beat(ACT_ORBIT, 0, 0, 0, 0, 0, 0, 20'h80000, 20'h7FFFF, 0)));
    rows.push_back(plain(beat(ACT_DOLLY, 0, 0, 0, 0, 0, 0, 0, 0, one)));
    rows.push_back(known(beat(ACT_SET_VIEW, mn, mn, mn, mx, mx, mx, 0, 0, 0),
                         '{mn, mn, mn, mx, mx, mx}));
    rows.push_back(plain(beat(ACT_ORBIT, 0, 0, 0, 0, 0, 0, 20'h12345, 20'h01000, 0)));
    rows.push_back(plain(beat(ACT_DOLLY, 0, 0, 0, 0, 0, 0, 0, 0, mn)));
    rows.push_back(plain(beat(ACT_RESTRICT, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(known(beat(ACT_SET_VIEW, mx, 0, mn, mn, 0, mx, 0, 0, 0),
                         '{mx, 0, mn, mn, 0, mx}));
    rows.push_back(plain(beat(ACT_DOLLY, 0, 0, 0, 0, 0, 0, 0, 0, mx)));
    rows.push_back(known(beat(ACT_SET_VIEW, 5 * one, 5 * one, 5 * one, 5 * one, 5 * one,
                              5 * one, 0, 0, 0), '{5 * one, 5 * one, 5 * one, 5 * one,
                              5 * one, 5 * one}));
    rows.push_back(plain(beat(ACT_ORBIT, 0, 0, 0, 0, 0, 0, 20'h10000, 20'h10000, 0)));
    rows.push_back(plain(beat(ACT_DOLLY, 0, 0, 0, 0, 0, 0, 0, 0, one)));
    rows.push_back(known(beat(ACT_SET_VIEW, 0, 0, 1, 0, 0, 0, 0, 0, 0), '{0, 0, 1, 0, 0, 0}));
    rows.push_back(plain(beat(ACT_RESTRICT, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(known(beat(ACT_SET_VIEW, 0, 0, 100 * one, 0, 0, 0, 0, 0, 0),
                         '{0, 0, 100 * one, 0, 0, 0}));
    rows.push_back(plain(beat(ACT_RESTRICT, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(plain(beat(ACT_ORBIT, 0, 0, 0, 0, 0, 0, 20'h00000, 20'h7FFFF, 0)));
    rows.push_back(plain(beat(ACT_ORBIT, 0, 0, 0, 0, 0, 0, 20'h00000, 20'h80000, 0)));
    rows.push_back(plain(beat(ACT_DOLLY, 0, 0, 0, 0, 0, 0, 0, 0, -32'sd196608)));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin lo_lim = 31'd0; hi_lim = 31'h7FFFFFFF; end
        1: begin lo_lim = 31'h7FFFFFFF; hi_lim = 31'd0; end
        2: begin lo_lim = 31'($urandom_range(0, 262144)); hi_lim = 31'($urandom()); end
        3: begin lo_lim = 31'($urandom()); hi_lim = 31'($urandom()); end
        default: begin lo_lim = MIN_DIST_RESET; hi_lim = MAX_DIST_RESET; end
      endcase
      write_reg(CFG_MIN_DIST, lo_lim);
      write_reg(CFG_MAX_DIST, hi_lim);
      if (phase == 2) hold_pending = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) send(rand_beat(), 1'b0, zero_view);
    end

    in_if.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("orbit_camera_controller_top_tb OK");
    end else begin
      $display("orbit_camera_controller_top_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
